FILE: src/float_alu_add_sub_mul_cmp_core_macros.svh
// assertion macros for the float alu checker
`ifndef FLOAT_ALU_ADD_SUB_MUL_CMP_CORE_MACROS_SVH
`define FLOAT_ALU_ADD_SUB_MUL_CMP_CORE_MACROS_SVH
// implication checked on every clock edge outside reset
`define FA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication checked outside reset
`define FA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

FILE: src/fa_pkg.sv
// shared types and constants for the float alu
package fa_pkg;
    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_NEG = 3'd3,
        OP_GT  = 3'd4,
        OP_SAR = 3'd5
    } t_op;

    localparam logic [31:0] QNAN = 32'h7FC0_0000;
    localparam logic [31:0] INF  = 32'h7F80_0000;

    // unrounded value: sign, exponent of bit 0 of mag, 64-bit magnitude
    typedef struct packed {
        logic              sign;
        logic signed [10:0] exp;
        logic [63:0]       mag;
    } t_unr;

    // finished special case flags carried alongside
    typedef struct packed {
        logic        done;
        logic [31:0] value;
    } t_fix;
endpackage

FILE: src/fa_round.sv
// normalize and round an unrounded value to binary32, three register stages
module fa_round
    import fa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  t_unr        i_unr,
    input  t_fix        i_fix,
    output logic [31:0] o_result
);
    // stage 1: leading one position
    logic [5:0] n_p;
    logic       n_zero;
    always_comb begin
        n_p    = 6'd0;
        n_zero = (i_unr.mag == 64'd0);
        for (int i = 0; i < 64; i++) begin
            if (i_unr.mag[i]) n_p = 6'(i);
        end
    end

    t_unr       r1_unr;
    t_fix       r1_fix;
    logic [5:0] r1_p;
    logic       r1_zero;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_unr  <= i_unr;
            r1_fix  <= i_fix;
            r1_p    <= n_p;
            r1_zero <= n_zero;
        end
    end

    // stage 2: shift amount and shifted value with sticky
    logic signed [12:0] n_sh;
    logic signed [12:0] n_shmin;
    logic [25:0]        n_q2;     // q with guard bit in bit 0
    logic               n_stk;
    always_comb begin
        n_sh    = 13'(signed'({7'd0, r1_p})) - 13'sd23;
        n_shmin = -13'sd149 - 13'(r1_unr.exp);
        if (n_shmin > n_sh) n_sh = n_shmin;
        n_q2  = 26'd0;
        n_stk = 1'b0;
        if (n_sh > 13'sd0) begin
            if (n_sh <= 13'sd64) begin
                n_q2  = 26'((r1_unr.mag >> (n_sh - 13'sd1)));
                n_stk = n_sh > 13'sd1 &&
                        ((r1_unr.mag & ((64'd1 << (n_sh - 13'sd1)) - 64'd1)) != 64'd0);
            end else begin
                n_stk = 1'b1;
            end
        end else begin
            n_q2 = 26'(r1_unr.mag << (13'sd1 - n_sh));
        end
    end

    t_fix               r2_fix;
    logic               r2_sign;
    logic               r2_zero;
    logic signed [12:0] r2_be;
    logic [25:0]        r2_q2;
    logic               r2_stk;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_fix  <= r1_fix;
            r2_sign <= r1_unr.sign;
            r2_zero <= r1_zero;
            r2_be   <= 13'(r1_unr.exp) + n_sh + 13'sd150;
            r2_q2   <= n_q2;
            r2_stk  <= n_stk;
        end
    end

    // stage 3: round, renormalize, pack
    logic [24:0]        n_q;
    logic signed [12:0] n_be;
    logic [31:0]        n_res;
    always_comb begin
        n_q  = r2_q2[25:1];
        n_be = r2_be;
        if (r2_q2[0] && (r2_stk || n_q[0])) n_q = n_q + 25'd1;
        if (n_q[24]) begin
            n_q  = n_q >> 1;
            n_be = n_be + 13'sd1;
        end
        if (r2_fix.done)        n_res = r2_fix.value;
        else if (r2_zero)       n_res = {r2_sign, 31'd0};
        else if (!n_q[23])      n_res = {r2_sign, 8'd0, n_q[22:0]};
        else if (n_be >= 13'sd255) n_res = {r2_sign, INF[30:0]};
        else                    n_res = {r2_sign, n_be[7:0], n_q[22:0]};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) o_result <= n_res;
    end
endmodule

FILE: src/float_alu_add_sub_mul_cmp_core.sv
// top level of the single precision float alu
// an accepted input beat moves through the stages listed below to the result beat on the output register
// throughput: one beat per cycle; the whole pipe advances when the output is free
// stages: operand decode, align or multiply, leading one, shift, round and pack
// reset: synchronous active low i_rst_n clears the stage valid bits only
module float_alu_add_sub_mul_cmp_core
    import fa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // operand_a [31:0], operand_b [63:32]
    input  logic [2:0]  s_axis_tuser,  // opcode [2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata   // result [31:0]
);
    // pipe moves as a whole whenever the output stage can drain
    logic       w_en;
    logic [4:0] r_vld;
    assign w_en          = !r_vld[4] || m_axis_tready;
    assign s_axis_tready = w_en;
    assign m_axis_tvalid = r_vld[4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[3:0], s_axis_tvalid};
        end
    end

    // stage a: register operands
    logic [2:0]  r_op;
    logic [31:0] r_a, r_b;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_op <= s_axis_tuser;
            r_a  <= s_axis_tdata[31:0];
            r_b  <= s_axis_tdata[63:32];
        end
    end

    // stage b: special cases, alignment for add, 24x24 multiply, negate, compare, arithmetic shift
    logic        w_nan_a, w_nan_b, w_inf_a, w_inf_b;
    logic [31:0] w_b;          // b with sign flipped for subtract
    t_fix        n_fix;
    t_unr        n_unr;
    logic [23:0] w_ma, w_mb;
    logic [47:0] w_prod;       // full significand product
    logic signed [10:0] w_ea, w_eb;
    logic [63:0] w_hi, w_lo;
    logic signed [10:0] w_d;
    logic        w_sa, w_sb, w_swap;
    logic signed [32:0] w_ka, w_kb;
    logic [4:0]  w_n;

    always_comb begin
        w_nan_a = r_a[30:0] > INF[30:0];
        w_nan_b = r_b[30:0] > INF[30:0];
        w_inf_a = r_a[30:0] == INF[30:0];
        w_inf_b = r_b[30:0] == INF[30:0];
        w_b     = (t_op'(r_op) == OP_SUB) ? {~r_b[31], r_b[30:0]} : r_b;
        w_ma    = (r_a[30:23] == 8'd0) ? {1'b0, r_a[22:0]} : {1'b1, r_a[22:0]};
        w_mb    = (w_b[30:23] == 8'd0) ? {1'b0, w_b[22:0]} : {1'b1, w_b[22:0]};
        w_prod  = w_ma * w_mb;
        w_ea    = (r_a[30:23] == 8'd0) ? -11'sd149 : 11'(r_a[30:23]) - 11'sd150;
        w_eb    = (w_b[30:23] == 8'd0) ? -11'sd149 : 11'(w_b[30:23]) - 11'sd150;
        w_swap  = w_ea < w_eb;
        w_sa    = w_swap ? w_b[31] : r_a[31];
        w_sb    = w_swap ? r_a[31] : w_b[31];
        w_d     = w_swap ? (w_eb - w_ea) : (w_ea - w_eb);
        w_hi    = {8'd0, (w_swap ? w_mb : w_ma), 32'd0};
        if (w_d <= 11'sd32) begin
            w_lo = {8'd0, (w_swap ? w_ma : w_mb), 32'd0} >> w_d;
        end else begin
            // beyond 32 the small operand only feeds sticky
            w_lo = {63'd0, (w_swap ? w_ma : w_mb) != 24'd0};
        end
        w_ka = r_a[31] ? -33'(signed'({2'b0, r_a[30:0]})) : 33'(signed'({2'b0, r_a[30:0]}));
        w_kb = r_b[31] ? -33'(signed'({2'b0, r_b[30:0]})) : 33'(signed'({2'b0, r_b[30:0]}));
        w_n  = (r_b > 32'd31) ? 5'd31 : r_b[4:0];

        n_fix = '{done: 1'b1, value: 32'd0};
        n_unr = '{sign: 1'b0, exp: 11'sd0, mag: 64'd0};
        case (t_op'(r_op))
            OP_ADD, OP_SUB: begin
                if (w_nan_a || w_nan_b) n_fix.value = QNAN;
                else if (w_inf_a && w_inf_b)
                    n_fix.value = (r_a[31] != w_b[31]) ? QNAN : r_a;
                else if (w_inf_a) n_fix.value = r_a;
                else if (w_inf_b) n_fix.value = w_b;
                else if (w_sa != w_sb && w_hi == w_lo) n_fix.value = 32'd0;
                else begin
                    n_fix.done = 1'b0;
                    n_unr.exp  = w_swap ? w_eb - 11'sd32 : w_ea - 11'sd32;
                    if (w_sa == w_sb) begin
                        n_unr.sign = w_sa;
                        n_unr.mag  = w_hi + w_lo;
                    end else if (w_hi > w_lo) begin
                        n_unr.sign = w_sa;
                        n_unr.mag  = w_hi - w_lo;
                    end else begin
                        n_unr.sign = w_sb;
                        n_unr.mag  = w_lo - w_hi;
                    end
                end
            end
            OP_MUL: begin
                if (w_nan_a || w_nan_b) n_fix.value = QNAN;
                else if (w_inf_a || w_inf_b) begin
                    if (r_a[30:0] == 31'd0 || r_b[30:0] == 31'd0) n_fix.value = QNAN;
                    else n_fix.value = {r_a[31] ^ r_b[31], INF[30:0]};
                end else begin
                    n_fix.done = 1'b0;
                    n_unr.sign = r_a[31] ^ r_b[31];
                    n_unr.exp  = w_ea + w_eb;
                    n_unr.mag  = {16'd0, w_prod};
                end
            end
            OP_NEG: n_fix.value = {~r_a[31], r_a[30:0]};
            OP_GT:  n_fix.value = {31'd0, !(w_nan_a || w_nan_b) && (w_ka > w_kb)};
            OP_SAR: n_fix.value = 32'($signed(r_a) >>> w_n);
            default: n_fix.value = 32'd0;
        endcase
    end

    t_fix r_fix;
    t_unr r_unr;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fix <= n_fix;
            r_unr <= n_unr;
        end
    end

    fa_round u_round (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_unr    (r_unr),
        .i_fix    (r_fix),
        .o_result (m_axis_tdata)
    );
endmodule

FILE: src/fa_checker.sv
// port level checks for the float alu, bound to the top level
`include "float_alu_add_sub_mul_cmp_core_macros.svh"
module fa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);
    logic w_stall;
    assign w_stall = m_axis_tvalid && !m_axis_tready;

    `FA_ASSERT_NEXT(a_hold_data, i_clk, i_rst_n, w_stall, $stable(m_axis_tdata))
    `FA_ASSERT_IMPL(a_ready_free, i_clk, i_rst_n, !m_axis_tvalid, s_axis_tready)
    `FA_ASSERT_IMPL(a_ready_stall, i_clk, i_rst_n, w_stall, !s_axis_tready)
endmodule

bind float_alu_add_sub_mul_cmp_core fa_checker u_fa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
